FILE: sv/jetp_pkg.sv
// Shared constants, item struct and palette ROM for the Julia escape-time pixel engine.
// Used by jetp_iter and julia_escape_time_pixel; depends on nothing else.
package jetp_pkg;

	localparam int FRAC_BITS    = 28;
	localparam int PALETTE_SIZE = 39;
	localparam int N_ITER       = PALETTE_SIZE - 1;
	localparam int ROM_N        = 39;

	localparam int CNT_W     = 6;
	localparam int Z_W       = FRAC_BITS + 4;
	localparam int MAG_W     = FRAC_BITS + 8;
	localparam int NZ_W      = MAG_W + 2;
	localparam int STEP_W    = 31;
	localparam int PIX_W     = 12;
	localparam int SP_W      = STEP_W + PIX_W;
	localparam int COLOR_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 36;

	// round(1.8 * 2^FRAC_BITS)
	localparam longint ONE_POINT_EIGHT = ((longint'(18) << FRAC_BITS) + 5) / 10;

	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;

	localparam logic [STEP_W-1:0] RST_REAL_STEP = 31'd1509949;
	localparam logic [STEP_W-1:0] RST_IMAG_STEP = 31'd2013265;
	localparam logic [MAG_W-1:0]  RST_THRESHOLD = 36'd1073741824;

	typedef struct packed {
		logic                    valid;
		logic                    done;   // escape count settled
		logic                    chk;    // magnitude of current z still to be tested
		logic [CNT_W-1:0]        count;
		logic signed [Z_W-1:0]   zr;
		logic signed [Z_W-1:0]   zi;
	} jetp_item_t;

	localparam logic [COLOR_W-1:0] PALETTE [ROM_N] = '{
		24'h000000, 24'h000044, 24'h000088, 24'h0000aa, 24'h0000ff, 24'h0044ff, 24'h0088ff,
		24'h00aaff, 24'h00ffff, 24'h44ffaa, 24'h88ff88, 24'haaff44, 24'hffff00, 24'hffaa00,
		24'hff8800, 24'hff4400, 24'hff0000, 24'haa0000, 24'h880000, 24'h440000, 24'h440044,
		24'h880088, 24'haa00aa, 24'hff00ff, 24'hff4400, 24'hff8800, 24'hffaa00, 24'hffff00,
		24'haaff44, 24'h88ff88, 24'h44ffaa, 24'h00ffff, 24'h00aaff, 24'h0088ff, 24'hff4400,
		24'hff00ff, 24'haa00aa, 24'h880088, 24'h440044
	};

endpackage

FILE: sv/jetp_iter.sv
// One z = z*z + c iteration as two pipeline stages: products, then sums and escape tests.
// Also tests the magnitude of the incoming z using its own squares. Uses jetp_pkg.
module jetp_iter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [jetp_pkg::CNT_W-1:0]        iter_idx,
	input  logic                              step_en,
	input  logic signed [jetp_pkg::Z_W-1:0]   c_real,
	input  logic signed [jetp_pkg::Z_W-1:0]   c_imag,
	input  logic [jetp_pkg::MAG_W-1:0]        threshold,
	input  jetp_pkg::jetp_item_t              in_item,
	output jetp_pkg::jetp_item_t              out_item
);
	import jetp_pkg::*;

	typedef struct packed {
		logic                    done;
		logic                    chk;
		logic [CNT_W-1:0]        count;
		logic [MAG_W-1:0]        sq_r;
		logic [MAG_W-1:0]        sq_i;
		logic signed [MAG_W-1:0] cross_fl;
		logic                    cross_corr;
	} prod_t;

	logic signed [2*Z_W-1:0] p_rr, p_ii, p_ri;
	prod_t                   prod_d, prod_s1;
	logic                    valid_s1, valid_s2;
	jetp_item_t              next_d, item_s2;

	logic [MAG_W:0]          mag;
	logic                    esc_mag;
	logic signed [NZ_W-1:0]  nr, ni;
	logic                    nr_ok, ni_ok;

	// stage 1: the three products of z
	always_comb begin
		p_rr = in_item.zr * in_item.zr;
		p_ii = in_item.zi * in_item.zi;
		p_ri = in_item.zr * in_item.zi;
		prod_d.done       = in_item.done;
		prod_d.chk        = in_item.chk;
		prod_d.count      = in_item.count;
		prod_d.sq_r       = p_rr[2*Z_W-1:FRAC_BITS];
		prod_d.sq_i       = p_ii[2*Z_W-1:FRAC_BITS];
		prod_d.cross_fl   = p_ri[2*Z_W-1:FRAC_BITS];
		// round toward zero: bump a negative product with nonzero dropped bits
		prod_d.cross_corr = p_ri[2*Z_W-1] & (|p_ri[FRAC_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= prod_d;
		end
	end

	// stage 2: magnitude test of incoming z, then new z and its range test
	always_comb begin
		mag     = {1'b0, prod_s1.sq_r} + {1'b0, prod_s1.sq_i};
		esc_mag = prod_s1.chk && (mag > {1'b0, threshold});
		nr = $signed({2'b00, prod_s1.sq_r}) - $signed({2'b00, prod_s1.sq_i})
			+ {{(NZ_W-Z_W){c_real[Z_W-1]}}, c_real};
		ni = {prod_s1.cross_fl[MAG_W-1], prod_s1.cross_fl, 1'b0}
			+ {{(NZ_W-2){1'b0}}, prod_s1.cross_corr, 1'b0}
			+ {{(NZ_W-Z_W){c_imag[Z_W-1]}}, c_imag};
		nr_ok = (&nr[NZ_W-1:Z_W-1]) | ~(|nr[NZ_W-1:Z_W-1]);
		ni_ok = (&ni[NZ_W-1:Z_W-1]) | ~(|ni[NZ_W-1:Z_W-1]);

		next_d.valid = 1'b0;
		next_d.done  = prod_s1.done;
		next_d.chk   = step_en;
		next_d.count = prod_s1.count;
		next_d.zr    = nr[Z_W-1:0];
		next_d.zi    = ni[Z_W-1:0];
		if (!prod_s1.done) begin
			if (esc_mag) begin
				next_d.done  = 1'b1;
				next_d.count = iter_idx - CNT_W'(1);
			end else if (step_en && !(nr_ok && ni_ok)) begin
				next_d.done  = 1'b1;
				next_d.count = iter_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= next_d;
		end
	end

	always_comb begin
		out_item       = item_s2;
		out_item.valid = valid_s2;
	end

	// a settled count rides through untouched
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && prod_s1.done && advance) |=>
		(item_s2.done && item_s2.count == $past(prod_s1.count)))
		else $error("settled escape count changed in iteration stage");

	a_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !item_s2.done) |-> (item_s2.count == '0))
		else $error("unsettled item carries a nonzero count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && item_s2.done) |-> (item_s2.count != '0 && item_s2.count <= iter_idx))
		else $error("escape count outside this stage's reach");

endmodule

FILE: sv/julia_escape_time_pixel.sv
// Top level of the Julia escape-time pixel engine: config registers, start point,
// iteration pipeline and palette output stage. Uses jetp_pkg and jetp_iter.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one pixel word, pixel_x and pixel_y.
//   Output channel (out_valid / out_stall) delivers pixel_color and escape_count.
//   Config channel (cfg_valid / cfg_ready) writes real_step, imag_step, c_real,
//   c_imag and escape_threshold by index 0..4; other indexes are dropped.
//   cfg_ready is always high; write only while no pixel is in flight.
// Timing:
//   A pixel enters every cycle unless in_stall is raised. It passes 81 register stages,
//   the first loaded at the accepting edge: 2 stages build the start point, each
//   of the 38 iterations takes 2 stages (products, then sums and escape tests),
//   2 more stages test the last magnitude, and 1 stage reads the palette ROM into
//   the output register. The 38 unrolled iteration units make up most of the stages.
// Reset:
//   arst_n clears all valid bits and loads the register defaults.
// Stall:
//   While out_valid is held by out_stall the whole pipeline freezes and
//   in_stall is raised; nothing is lost or repeated.
module julia_escape_time_pixel (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [jetp_pkg::PIX_W-1:0]           pixel_x,
	input  logic [jetp_pkg::PIX_W-1:0]           pixel_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [jetp_pkg::COLOR_W-1:0]         pixel_color,
	output logic [jetp_pkg::CNT_W-1:0]           escape_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [jetp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [jetp_pkg::CFG_W-1:0]           cfg_data
);
	import jetp_pkg::*;

	logic [STEP_W-1:0]       real_step_q, imag_step_q;
	logic signed [Z_W-1:0]   c_real_q, c_imag_q;
	logic [MAG_W-1:0]        threshold_q;

	logic                    advance;
	logic                    valid_s1, valid_s2;
	logic [SP_W-1:0]         prod_x_s1, prod_y_s1;
	logic signed [SP_W+1:0]  zr_w, zi_w;
	logic                    zr_ok, zi_ok;
	jetp_item_t              start_d, item_s2;
	jetp_item_t              chain [N_ITER+1];
	jetp_item_t              fin_item;

	logic                    out_valid_q;
	logic [COLOR_W-1:0]      color_q;
	logic [CNT_W-1:0]        count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_step_q <= RST_REAL_STEP;
			imag_step_q <= RST_IMAG_STEP;
			c_real_q    <= '0;
			c_imag_q    <= '0;
			threshold_q <= RST_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REAL_STEP: real_step_q <= cfg_data[STEP_W-1:0];
				REG_IMAG_STEP: imag_step_q <= cfg_data[STEP_W-1:0];
				REG_C_REAL:    c_real_q    <= cfg_data[Z_W-1:0];
				REG_C_IMAG:    c_imag_q    <= cfg_data[Z_W-1:0];
				REG_THRESHOLD: threshold_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// hold everything while a finished word waits on a stalled receiver
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	// stage 1: step times coordinate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_x_s1 <= SP_W'(real_step_q) * SP_W'(pixel_x);
			prod_y_s1 <= SP_W'(imag_step_q) * SP_W'(pixel_y);
		end
	end

	// stage 2: start point and its range test
	always_comb begin
		zr_w  = $signed({2'b00, prod_x_s1}) - $signed((SP_W+2)'(ONE_POINT_EIGHT));
		zi_w  = $signed((SP_W+2)'(ONE_POINT_EIGHT)) - $signed({2'b00, prod_y_s1});
		zr_ok = (&zr_w[SP_W+1:Z_W-1]) | ~(|zr_w[SP_W+1:Z_W-1]);
		zi_ok = (&zi_w[SP_W+1:Z_W-1]) | ~(|zi_w[SP_W+1:Z_W-1]);
		start_d.valid = 1'b0;
		start_d.done  = !(zr_ok && zi_ok);
		start_d.chk   = 1'b0;
		start_d.count = (zr_ok && zi_ok) ? '0 : CNT_W'(1);
		start_d.zr    = zr_w[Z_W-1:0];
		start_d.zi    = zi_w[Z_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= start_d;
		end
	end

	always_comb begin
		chain[0]       = item_s2;
		chain[0].valid = valid_s2;
	end

	genvar k;
	generate
		for (k = 1; k <= N_ITER; k++) begin : g_iter
			jetp_iter u_iter (
				.clk       (clk),
				.arst_n    (arst_n),
				.advance   (advance),
				.iter_idx  (CNT_W'(k)),
				.step_en   (1'b1),
				.c_real    (c_real_q),
				.c_imag    (c_imag_q),
				.threshold (threshold_q),
				.in_item   (chain[k-1]),
				.out_item  (chain[k])
			);
		end
	endgenerate

	// magnitude test of the last z only
	jetp_iter u_last (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.iter_idx  (CNT_W'(PALETTE_SIZE)),
		.step_en   (1'b0),
		.c_real    (c_real_q),
		.c_imag    (c_imag_q),
		.threshold (threshold_q),
		.in_item   (chain[N_ITER]),
		.out_item  (fin_item)
	);

	// output register with palette lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fin_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_q <= PALETTE[fin_item.count];
			count_q <= fin_item.count;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_color  = color_q;
	assign escape_count = count_q;

endmodule

FILE: sim/julia_escape_time_pixel_tb.sv
// Self-checking testbench for julia_escape_time_pixel: drives pixel words and register writes,
// predicts escape count and palette color per pixel, and checks every output word in order.
// Depends on jetp_pkg and the julia_escape_time_pixel RTL only.
module julia_escape_time_pixel_tb;
	import jetp_pkg::*;

	localparam int     HALF_PERIOD  = 6;
	localparam int     IDLE_PCT     = 9;
	localparam int     HOLD_CYCLES  = 200;
	localparam int     TAIL_CYCLES  = 120;
	localparam int     LIMIT_CYCLES = 200000;
	localparam int     REPORT_MAX   = 10;
	localparam int     RAND_PHASES  = 8;
	localparam int     PHASE_ITEMS  = 190;
	localparam int     LAST_ITER    = PALETTE_SIZE;
	localparam longint FX_1P8       = ((longint'(18) << FRAC_BITS) + 5) / 10;
	localparam longint FX_LIMIT     = longint'(8) << FRAC_BITS;
	// 3.6 in Q4.28; step for a frame of width w is this over w
	localparam longint SPAN_3P6     = 64'd966367642;

	localparam logic [STEP_W-1:0] STEP_RE_RST = 31'd1509949;
	localparam logic [STEP_W-1:0] STEP_IM_RST = 31'd2013265;
	localparam logic [MAG_W-1:0]  LIMIT_RST   = 36'd1073741824;
	localparam logic [MAG_W-1:0]  LIMIT_FOUR  = 36'd1073741824;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_THRESHOLD + 3'd1;

	localparam logic [COLOR_W-1:0] SHADE_ROM [39] = '{
		24'h000000, 24'h000044, 24'h000088, 24'h0000aa, 24'h0000ff, 24'h0044ff, 24'h0088ff,
		24'h00aaff, 24'h00ffff, 24'h44ffaa, 24'h88ff88, 24'haaff44, 24'hffff00, 24'hffaa00,
		24'hff8800, 24'hff4400, 24'hff0000, 24'haa0000, 24'h880000, 24'h440000, 24'h440044,
		24'h880088, 24'haa00aa, 24'hff00ff, 24'hff4400, 24'hff8800, 24'hffaa00, 24'hffff00,
		24'haaff44, 24'h88ff88, 24'h44ffaa, 24'h00ffff, 24'h00aaff, 24'h0088ff, 24'hff4400,
		24'hff00ff, 24'haa00aa, 24'h880088, 24'h440044
	};

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} coord_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   count;
	} shade_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel_x = '0;
	logic [PIX_W-1:0]     pixel_y = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COLOR_W-1:0]   pixel_color;
	logic [CNT_W-1:0]     escape_count;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// register copies for the predictor
	logic [STEP_W-1:0]    step_re = STEP_RE_RST;
	logic [STEP_W-1:0]    step_im = STEP_IM_RST;
	logic signed [31:0]   c_re = '0;
	logic signed [31:0]   c_im = '0;
	logic [MAG_W-1:0]     esc_limit = LIMIT_RST;

	coord_t coord_q [$];
	shade_t shade_q [$];
	int     n_bad = 0;
	int     frame_w = 640;
	int     frame_h = 480;
	logic   calm = 1'b0;
	int     hold_left = 0;
	logic   hold_done = 1'b0;

	julia_escape_time_pixel u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_color (pixel_color),
		.escape_count(escape_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Signed fixed-point product, truncated toward zero.
	function automatic longint fx_mul(input longint a, input longint b);
		longint unsigned ma, mb, p;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma * mb) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic fx_ok(input longint v);
		return v >= -FX_LIMIT && v < FX_LIMIT;
	endfunction

	function automatic shade_t shade_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
		longint zr, zi, nr, ni, mag;
		int n, cnt;
		shade_t s;
		zr = longint'(step_re) * longint'(px) - FX_1P8;
		zi = FX_1P8 - longint'(step_im) * longint'(py);
		cnt = 0;
		if (!fx_ok(zr) || !fx_ok(zi)) begin
			cnt = 1;
		end else begin
			for (n = 1; n < LAST_ITER && cnt == 0; n++) begin
				nr = fx_mul(zr, zr) - fx_mul(zi, zi) + longint'(c_re);
				ni = 2 * fx_mul(zr, zi) + longint'(c_im);
				if (!fx_ok(nr) || !fx_ok(ni)) begin
					cnt = n;
				end else begin
					mag = fx_mul(nr, nr) + fx_mul(ni, ni);
					if (mag > longint'(esc_limit)) begin
						cnt = n;
					end
					zr = nr;
					zi = ni;
				end
			end
		end
		s.color = SHADE_ROM[cnt];
		s.count = CNT_W'(cnt);
		return s;
	endfunction

	function automatic logic [31:0] to_fx(input real r);
		return 32'($rtoi(r * 268435456.0));
	endfunction

	function automatic logic [CFG_W-1:0] rand36();
		return CFG_W'({$urandom(), $urandom()});
	endfunction

	// Sender: hold a stalled word, otherwise present the next pending one or idle.
	always @(posedge clk or negedge arst_n) begin
		coord_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				shade_q.push_back(shade_pixel(pixel_x, pixel_y));
			end
			if (!in_valid || !in_stall) begin
				if (coord_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = coord_q.pop_front();
					in_valid <= 1'b1;
					pixel_x <= nxt.x;
					pixel_y <= nxt.y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold while plenty is queued, so the pipe fills and backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && coord_q.size() > 120) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver: check each accepted word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		shade_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (shade_q.size() == 0) begin
					n_bad++;
					if (n_bad <= REPORT_MAX) begin
						$display("unexpected output word: color %06h count %0d",
							pixel_color, escape_count);
					end
				end else begin
					want = shade_q.pop_front();
					if (pixel_color !== want.color || escape_count !== want.count) begin
						n_bad++;
						if (n_bad <= REPORT_MAX) begin
							$display("mismatch: color exp %06h got %06h, count exp %0d got %0d",
								want.color, pixel_color, want.count, escape_count);
						end
					end
				end
			end
			out_stall <= (hold_left > 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic offer(input int x, input int y);
		coord_t c;
		c.x = PIX_W'(x);
		c.y = PIX_W'(y);
		coord_q.push_back(c);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (coord_q.size() != 0 || in_valid || shade_q.size() != 0);
	endtask

	// Call on a rising edge; leaves cfg_valid high for back-to-back writes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_REAL_STEP: step_re = data[STEP_W-1:0];
			REG_IMAG_STEP: step_im = data[STEP_W-1:0];
			REG_C_REAL:    c_re = data[31:0];
			REG_C_IMAG:    c_im = data[31:0];
			REG_THRESHOLD: esc_limit = data;
			default: ;
		endcase
	endtask

	task automatic write_c(input logic [31:0] re, input logic [31:0] im);
		write_reg(REG_C_REAL, {4'($urandom()), re});
		write_reg(REG_C_IMAG, {4'($urandom()), im});
	endtask

	task automatic write_steps(input logic [STEP_W-1:0] sr, input logic [STEP_W-1:0] si);
		write_reg(REG_REAL_STEP, {5'($urandom()), sr});
		write_reg(REG_IMAG_STEP, {5'($urandom()), si});
	endtask

	task automatic pick_classic_c(output real re, output real im);
		case ($urandom_range(0, 7))
			0: begin re = -0.8;     im = 0.156;   end
			1: begin re = 0.285;    im = 0.01;    end
			2: begin re = -0.4;     im = 0.6;     end
			3: begin re = -0.7269;  im = 0.1889;  end
			4: begin re = 0.355;    im = 0.355;   end
			5: begin re = -0.70176; im = -0.3842; end
			6: begin re = 0.0;      im = -0.8;    end
			default: begin re = -0.835; im = -0.2321; end
		endcase
	endtask

	task automatic random_phase(input int k);
		real cr, ci;
		int i;
		if (k == 3) begin
			frame_w = 4096;
			frame_h = 4096;
			write_steps(31'($urandom()), 31'($urandom()));
			write_c($urandom(), $urandom());
		end else begin
			frame_w = $urandom_range(16, 4095);
			frame_h = $urandom_range(16, 4095);
			write_steps(STEP_W'(SPAN_3P6 / frame_w), STEP_W'(SPAN_3P6 / frame_h));
			if (k % 2 == 0) begin
				pick_classic_c(cr, ci);
			end else begin
				cr = $urandom_range(0, 2400) / 1000.0 - 1.2;
				ci = $urandom_range(0, 2400) / 1000.0 - 1.2;
			end
			write_c(to_fx(cr), to_fx(ci));
		end
		case (k)
			2: write_reg(REG_THRESHOLD, {MAG_W{1'b1}});
			4: write_reg(REG_THRESHOLD, rand36());
			5: write_reg(REG_THRESHOLD, MAG_W'($urandom_range(0, 32'h8000_0000)));
			default: write_reg(REG_THRESHOLD, LIMIT_FOUR);
		endcase
		if (k == 1) begin
			write_reg(REG_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), rand36());
		end
		cfg_valid <= 1'b0;
		calm <= (k == 5);
		@(negedge clk);
		for (i = 0; i < PHASE_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 85) begin
				offer($urandom_range(0, frame_w - 1), $urandom_range(0, frame_h - 1));
			end else begin
				offer($urandom_range(0, 4095), $urandom_range(0, 4095));
			end
		end
		wait_drained();
	endtask

	initial begin
		int k;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: frame corners, start point out of range, a point that never escapes
		offer(0, 0);
		offer(4095, 4095);
		offer(0, 4095);
		offer(4095, 0);
		offer(320, 240);
		offer(4095, 240);
		offer(320, 4095);
		wait_drained();

		// huge threshold: only overflow ends a point; writes past the last register drop
		write_c(to_fx(-0.8), to_fx(0.156));
		write_reg(REG_THRESHOLD, {MAG_W{1'b1}});
		write_reg(REG_UNUSED, rand36());
		write_reg(REG_UNUSED + 3'd1, rand36());
		write_reg(REG_UNUSED + 3'd2, rand36());
		cfg_valid <= 1'b0;
		@(negedge clk);
		offer(320, 240);
		offer(100, 100);
		offer(500, 300);
		offer(4095, 4095);
		wait_drained();

		// largest steps, extreme constants, zero threshold
		write_steps({STEP_W{1'b1}}, {STEP_W{1'b1}});
		write_c(32'h8000_0000, 32'h7fff_ffff);
		write_reg(REG_THRESHOLD, '0);
		cfg_valid <= 1'b0;
		@(negedge clk);
		offer(0, 0);
		offer(1, 1);
		offer(2, 0);
		offer(0, 4095);
		offer(4095, 0);
		wait_drained();

		// zero steps, c at the other extremes, then zero threshold near the origin
		write_steps('0, '0);
		write_c(32'h7fff_ffff, 32'h8000_0000);
		cfg_valid <= 1'b0;
		@(negedge clk);
		offer(4095, 4095);
		offer(2048, 1024);
		wait_drained();
		write_steps(STEP_RE_RST, STEP_IM_RST);
		write_c('0, '0);
		cfg_valid <= 1'b0;
		@(negedge clk);
		offer(320, 240);
		offer(321, 240);
		wait_drained();

		for (k = 0; k < RAND_PHASES; k++) begin
			random_phase(k);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_bad == 0 && shade_q.size() == 0) begin
			$display("julia_escape_time_pixel_tb: PASS");
		end else begin
			$display("julia_escape_time_pixel_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("julia_escape_time_pixel_tb: FAIL");
		$finish;
	end

endmodule
